// ----- sv/equirect_to_perspective_remap_top_defines.svh -----
// assertion macros shared by the remap rtl
// needs signals named clock and reset in the module that uses them
`ifndef EQUIRECT_TO_PERSPECTIVE_REMAP_TOP_DEFINES_SVH
`define EQUIRECT_TO_PERSPECTIVE_REMAP_TOP_DEFINES_SVH

// same-cycle implication
`define EPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/epr_pkg.sv -----
// shared types and constants of the equirect-to-perspective remap
// no dependencies
`timescale 1ns / 1ps

package epr_pkg;

   // csr port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STRIDE  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTICAL_TAN = 3'd5;

   localparam int STRIDE_BITS = 14;
   localparam int VTAN_BITS   = 17;
   localparam logic [VTAN_BITS-1:0] VTAN_ONE = 17'd65536;

   // register reset values
   localparam int RST_DEST_WIDTH   = 320;
   localparam int RST_DEST_HEIGHT  = 200;
   localparam int RST_SRC_WIDTH    = 1080;
   localparam int RST_SRC_HEIGHT   = 1920;
   localparam logic [STRIDE_BITS-1:0] RST_LINE_STRIDE  = 14'd3240;
   localparam logic [VTAN_BITS-1:0]   RST_VERTICAL_TAN = 17'd35032;

   // angle accumulator, Q0.32 turns
   localparam int ANGLE_BITS = 32;
   localparam int ANGLE_ENTRIES = 24;

   // atan(2^-i) in Q0.32 turns
   localparam logic signed [ANGLE_BITS-1:0] ATAN_TURNS [ANGLE_ENTRIES] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
      32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
      32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
      32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
      32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
      32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
   };

   // sign and saturation of a normalized offset, travels with the divider
   typedef struct packed {
      logic neg;
      logic sat;
   } div_flags_type;

endpackage

// ----- sv/epr_div_cell.sv -----
// one restoring-division cell: one quotient bit per cycle while load is high
// depends on epr_pkg
`timescale 1ns / 1ps

module epr_div_cell
   import epr_pkg::*;
#(
   parameter int DB = 10,
   parameter int F  = 16
) (
   input  logic          clock,
   input  logic          load,
   input  logic [DB-1:0] divisor,
   input  logic [DB-1:0] rem_i,
   input  logic [F-1:0]  quo_i,
   input  div_flags_type flags_i,
   output logic [DB-1:0] rem_o,
   output logic [F-1:0]  quo_o,
   output div_flags_type flags_o
);

   logic [DB:0]   shifted;
   logic [DB:0]   diff;
   logic          take;
   logic [DB-1:0] rem_in, rem_ff;
   logic [F-1:0]  quo_in, quo_ff;
   div_flags_type flags_ff;

   // trial subtract of the divisor from the doubled remainder
   always_comb begin
      shifted = {rem_i, 1'b0};
      take    = shifted >= {1'b0, divisor};
      diff    = shifted - {1'b0, divisor};
      rem_in  = take ? diff[DB-1:0] : shifted[DB-1:0];
      quo_in  = {quo_i[F-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         flags_ff <= flags_i;
      end
   end

   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;
   assign flags_o = flags_ff;

endmodule

// ----- sv/epr_cordic_cell.sv -----
// one vectoring cordic step, result angle in turns
// depends on epr_pkg
`timescale 1ns / 1ps

module epr_cordic_cell
   import epr_pkg::*;
#(
   parameter int XW   = 20,
   parameter int STEP = 0
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [XW-1:0]         x_i,
   input  logic signed [XW-1:0]         y_i,
   input  logic signed [ANGLE_BITS-1:0] z_i,
   output logic signed [XW-1:0]         x_o,
   output logic signed [XW-1:0]         y_o,
   output logic signed [ANGLE_BITS-1:0] z_o
);

   logic signed [XW-1:0]         dx, dy;
   logic signed [XW-1:0]         x_in, y_in, x_ff, y_ff;
   logic signed [ANGLE_BITS-1:0] z_in, z_ff;

   // rotate toward the x axis
   always_comb begin
      dx = y_i >>> STEP;
      dy = x_i >>> STEP;
      if (!y_i[XW-1]) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN_TURNS[STEP];
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN_TURNS[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

// ----- sv/equirect_to_perspective_remap_top.sv -----
// Equirect-to-perspective address generator. Takes one request per clock while
// the output is not stalled. Its stages are: setup, one division cell per
// quotient bit for the normalized offsets, normalize and tilt, one cordic
// cell per step, then scale, saturate and address stages. Every stage holds
// its result while the next one is full and cannot advance, so bubbles are
// squeezed out under backpressure. CSR writes are always taken and must only
// be made while no request is in flight.
// depends on epr_pkg, epr_div_cell, epr_cordic_cell and the defines header
`timescale 1ns / 1ps
`include "equirect_to_perspective_remap_top_defines.svh"

module equirect_to_perspective_remap_top
   import epr_pkg::*;
#(
   parameter int DEST_COORD_BITS = 10,
   parameter int SRC_COORD_BITS  = 12,
   parameter int FRAC_BITS       = 16,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [DEST_COORD_BITS-1:0]    req_out_x,
   input  logic [DEST_COORD_BITS-1:0]    req_out_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SRC_COORD_BITS-1:0]     rsp_src_col,
   output logic [SRC_COORD_BITS-1:0]     rsp_src_row,
   output logic [2*SRC_COORD_BITS+1:0]   rsp_src_offset,
   output logic [2*DEST_COORD_BITS+1:0]  rsp_dest_offset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int DB = DEST_COORD_BITS;
   localparam int SB = SRC_COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int C  = CORDIC_STEPS;
   localparam int XW = F + 4;
   localparam int PW = F + SB + 3;
   localparam int DOW = 2 * DB + 2;
   localparam int SOW = 2 * SB + 2;
   localparam int OW = (SB + 15 > SOW) ? SB + 15 : SOW;
   // stage numbers
   localparam int ST_NORM  = F + 1;
   localparam int ST_TILT  = F + 2;
   localparam int ST_CORD  = F + 3;
   localparam int ST_SCALE = F + 3 + C;
   localparam int ST_SAT   = F + 4 + C;
   localparam int NS       = F + 6 + C;

   // csr registers
   logic [DB-1:0]          dest_width_ff, dest_height_ff;
   logic [SB-1:0]          src_width_ff, src_height_ff;
   logic [STRIDE_BITS-1:0] line_stride_ff;
   logic [VTAN_BITS-1:0]   vertical_tan_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff   <= DB'(RST_DEST_WIDTH);
         dest_height_ff  <= DB'(RST_DEST_HEIGHT);
         src_width_ff    <= SB'(RST_SRC_WIDTH);
         src_height_ff   <= SB'(RST_SRC_HEIGHT);
         line_stride_ff  <= RST_LINE_STRIDE;
         vertical_tan_ff <= RST_VERTICAL_TAN;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEST_WIDTH:   dest_width_ff   <= csr_wdata[DB-1:0];
            CSR_DEST_HEIGHT:  dest_height_ff  <= csr_wdata[DB-1:0];
            CSR_SRC_WIDTH:    src_width_ff    <= csr_wdata[SB-1:0];
            CSR_SRC_HEIGHT:   src_height_ff   <= csr_wdata[SB-1:0];
            CSR_LINE_STRIDE:  line_stride_ff  <= csr_wdata[STRIDE_BITS-1:0];
            CSR_VERTICAL_TAN: vertical_tan_ff <= csr_wdata[VTAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamped view sizes and tangent
   logic [DB-1:0]        size_c [2];
   logic [VTAN_BITS-1:0] vtan_c;
   logic [SB-1:0]        col_top, row_top;

   always_comb begin
      size_c[0] = (dest_width_ff == '0) ? DB'(1) : dest_width_ff;
      size_c[1] = (dest_height_ff == '0) ? DB'(1) : dest_height_ff;
      vtan_c    = (vertical_tan_ff > VTAN_ONE) ? VTAN_ONE : vertical_tan_ff;
      col_top   = (src_width_ff == '0) ? '0 : src_width_ff - SB'(1);
      row_top   = (src_height_ff == '0) ? '0 : src_height_ff - SB'(1);
   end

   // stage valids and load enables, each stage frees when its successor moves
   logic [NS-1:0] v_ff, v_in, en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];

   // destination offset rides along the stages
   logic [DOW-1:0]  dof_ff [NS];
   logic [2*DB:0]   dpix;
   logic [2*DB+2:0] dof_full;

   always_comb begin
      dpix     = (2*DB+1)'(req_out_y * size_c[0]) + (2*DB+1)'(req_out_x);
      dof_full = {1'b0, dpix, 1'b0} + {2'b0, dpix};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dof_ff[0] <= dof_full[DOW-1:0];
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            dof_ff[k] <= dof_ff[k-1];
         end
      end
   end

   // setup: distance from view center, sign and saturation
   logic [DB-1:0]          coord [2];
   logic signed [DB+1:0]   cdiff [2];
   logic [DB:0]            cmag  [2];
   div_flags_type          flags_in [2];
   logic [DB-1:0]          rem0_in [2];
   logic [DB-1:0]          rem0_ff [2];
   div_flags_type          flags0_ff [2];

   assign coord[0] = req_out_x;
   assign coord[1] = req_out_y;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         cdiff[l]        = signed'({1'b0, coord[l], 1'b0}) - signed'({2'b0, size_c[l]});
         cmag[l]         = cdiff[l][DB+1] ? (DB+1)'(-cdiff[l]) : cdiff[l][DB:0];
         flags_in[l].neg = cdiff[l][DB+1];
         flags_in[l].sat = cmag[l] >= {1'b0, size_c[l]};
         rem0_in[l]      = cmag[l][DB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem0_ff   <= rem0_in;
         flags0_ff <= flags_in;
      end
   end

   // division cells, one per fraction bit, one row per axis
   logic [DB-1:0]  rem_c   [2][F+1];
   logic [F-1:0]   quo_c   [2][F+1];
   div_flags_type  flags_c [2][F+1];

   for (genvar l = 0; l < 2; l++) begin : g_div_lane
      assign rem_c[l][0]   = rem0_ff[l];
      assign quo_c[l][0]   = '0;
      assign flags_c[l][0] = flags0_ff[l];
      for (genvar j = 0; j < F; j++) begin : g_cell
         epr_div_cell #(.DB(DB), .F(F)) u_cell (
            .clock   (clock),
            .load    (en[j+1]),
            .divisor (size_c[l]),
            .rem_i   (rem_c[l][j]),
            .quo_i   (quo_c[l][j]),
            .flags_i (flags_c[l][j]),
            .rem_o   (rem_c[l][j+1]),
            .quo_o   (quo_c[l][j+1]),
            .flags_o (flags_c[l][j+1])
         );
      end
   end

   // normalize: signed Q1.F with saturation
   logic signed [F:0] norm_in [2];
   logic signed [F:0] norm_ff [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         priority if (flags_c[l][F].neg && flags_c[l][F].sat) begin
            norm_in[l] = {1'b1, {F{1'b0}}};
         end else if (flags_c[l][F].neg) begin
            norm_in[l] = -signed'({1'b0, quo_c[l][F]});
         end else if (flags_c[l][F].sat) begin
            norm_in[l] = {1'b0, {F{1'b1}}};
         end else begin
            norm_in[l] = signed'({1'b0, quo_c[l][F]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_NORM]) begin
         norm_ff <= norm_in;
      end
   end

   // tilt: row offset scaled by the vertical tangent
   logic [F:0]              ny_abs;
   logic [F+VTAN_BITS:0]    tilt_prod;
   logic [F:0]              tilt_mag;
   logic signed [XW-1:0]    cy_in [2];
   logic signed [XW-1:0]    cy0_ff [2];

   always_comb begin
      ny_abs    = norm_ff[1][F] ? (F+1)'(-norm_ff[1]) : norm_ff[1];
      tilt_prod = (F+VTAN_BITS+1)'(ny_abs * vtan_c);
      tilt_mag  = tilt_prod[F+16:16];
      cy_in[0]  = XW'(norm_ff[0]);
      cy_in[1]  = norm_ff[1][F] ? -XW'(signed'({1'b0, tilt_mag}))
                                :  XW'(signed'({1'b0, tilt_mag}));
   end

   always_ff @(posedge clock) begin
      if (en[ST_TILT]) begin
         cy0_ff <= cy_in;
      end
   end

   // cordic cells, one per step, one row per angle
   logic signed [XW-1:0]         cx [2][C+1];
   logic signed [XW-1:0]         cy [2][C+1];
   logic signed [ANGLE_BITS-1:0] cz [2][C+1];

   for (genvar l = 0; l < 2; l++) begin : g_cordic_lane
      assign cx[l][0] = XW'(signed'({1'b0, 1'b1, {F{1'b0}}}));
      assign cy[l][0] = cy0_ff[l];
      assign cz[l][0] = '0;
      for (genvar s = 0; s < C; s++) begin : g_cell
         epr_cordic_cell #(.XW(XW), .STEP(s)) u_cell (
            .clock (clock),
            .load  (en[ST_CORD+s]),
            .x_i   (cx[l][s]),
            .y_i   (cy[l][s]),
            .z_i   (cz[l][s]),
            .x_o   (cx[l][s+1]),
            .y_o   (cy[l][s+1]),
            .z_o   (cz[l][s+1])
         );
      end
   end

   // scale the turn fractions by the source size, centered
   logic signed [F-1:0]  yaw, pitch;
   logic signed [F+1:0]  yaw_c, pitch_c;
   logic signed [PW-1:0] scale_in [2];
   logic signed [PW-1:0] scale_ff [2];

   always_comb begin
      yaw         = cz[0][C][ANGLE_BITS-1:ANGLE_BITS-F];
      pitch       = cz[1][C][ANGLE_BITS-1:ANGLE_BITS-F];
      yaw_c       = (F+2)'(yaw) + (F+2)'(signed'({2'b0, 1'b1, {(F-1){1'b0}}}));
      pitch_c     = signed'({pitch[F-1], pitch, 1'b0})
                    + (F+2)'(signed'({2'b0, 1'b1, {(F-1){1'b0}}}));
      scale_in[0] = PW'(yaw_c) * PW'(signed'({1'b0, src_width_ff}));
      scale_in[1] = PW'(pitch_c) * PW'(signed'({1'b0, src_height_ff}));
   end

   always_ff @(posedge clock) begin
      if (en[ST_SCALE]) begin
         scale_ff <= scale_in;
      end
   end

   // floor and saturate to the source bounds
   logic signed [SB+2:0] pos [2];
   logic [SB-1:0]        top [2];
   logic [SB-1:0]        coord_in [2];
   logic [SB-1:0]        coord_ff [2];

   assign top[0] = col_top;
   assign top[1] = row_top;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         pos[l] = scale_ff[l][PW-1:F];
         priority if (pos[l] < 0) begin
            coord_in[l] = '0;
         end else if (pos[l] > signed'({3'b0, top[l]})) begin
            coord_in[l] = top[l];
         end else begin
            coord_in[l] = pos[l][SB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SAT]) begin
         coord_ff <= coord_in;
      end
   end

   // source byte offset and output register
   logic [OW-1:0]  soff_full;
   logic [SB-1:0]  col_ff, row_ff;
   logic [SOW-1:0] soff_ff;

   always_comb begin
      soff_full = OW'(coord_ff[1] * line_stride_ff)
                  + OW'({coord_ff[0], 1'b0}) + OW'(coord_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         col_ff  <= coord_ff[0];
         row_ff  <= coord_ff[1];
         soff_ff <= soff_full[SOW-1:0];
      end
   end

   assign rsp_src_col     = col_ff;
   assign rsp_src_row     = row_ff;
   assign rsp_src_offset  = soff_ff;
   assign rsp_dest_offset = dof_ff[NS-1];

   // checks
   `EPR_ASSERT_NOW(a_stall_only_when_full, !req_ready, v_ff[0],
                   "input stalled with an empty setup stage")
   `EPR_ASSERT_NOW(a_ready_when_drained, rsp_ready, req_ready,
                   "pipeline stalled while results drain")
   `EPR_ASSERT_NEXT(a_request_enters, req_valid && req_ready, v_ff[0],
                    "accepted request missing from setup stage")
   `EPR_ASSERT_NOW(a_cordic_x_positive, v_ff[ST_SCALE-1],
                   !cx[0][C][XW-1] && !cx[1][C][XW-1],
                   "cordic magnitude went negative")

endmodule
